[rtl/tlvff_pkg.sv]
// Package for the TLV field finder: parse phases, status codes, result beat
// and queue push request types, plus queue sizing constants.
// No dependencies.
package tlvff_pkg;

    typedef enum logic [2:0] {
        PH_TAG    = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_VALUE  = 3'd3,
        PH_DONE   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_SUCCESS   = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_MALFORMED = 2'd2
    } t_status;

    localparam logic KIND_VALUE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Result queue: two pushes per input beat at most.
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCOUNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  value_byte;
        logic [15:0] value_length;
        logic [1:0]  search_status;
        logic        is_last;
    } t_result;

    typedef struct packed {
        logic    val_en;
        logic    stat_en;
        t_result val_item;
        t_result stat_item;
    } t_push_req;

    typedef struct packed {
        logic [QCOUNT_W-1:0] count;
        logic                has_room;
    } t_queue_status;

endpackage

[rtl/tlvff_ifs.sv]
// Channel interfaces for the TLV field finder: input byte beats, result
// beats and the search tag write channel. Depends on tlvff_pkg.
interface tlvff_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       block_end;

    modport source (output valid, output data_byte, output block_end, input ready);
    modport sink   (input valid, input data_byte, input block_end, output ready);
endinterface

interface tlvff_result_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [7:0]  value_byte;
    logic [15:0] value_length;
    logic [1:0]  search_status;
    logic        is_last;

    modport source (output valid, output item_kind, output value_byte,
                    output value_length, output search_status, output is_last,
                    input ready);
    modport sink   (input valid, input item_kind, input value_byte,
                    input value_length, input search_status, input is_last,
                    output ready);
endinterface

interface tlvff_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] search_tag;

    modport source (output valid, output search_tag, input ready);
    modport sink   (input valid, input search_tag, output ready);
endinterface

[rtl/tlv_field_finder_unit.sv]
// Top level of the TLV field finder: search tag register, parser and
// result queue. Depends on tlvff_pkg, tlvff_ifs, tlvff_parser, tlvff_out_queue.
//
//   port     dir  beat carries
//   i_in     in   data_byte[7:0], block_end
//   o_out    out  item_kind, value_byte[7:0], value_length[15:0],
//                 search_status[1:0], is_last
//   i_cfg    in   search_tag[7:0] (always ready)
//
// While i_in.ready is high, one input byte is accepted per cycle; it updates
// the phase machine and pushes zero, one or two result beats into a 4-entry
// queue in that cycle. A result beat can leave in the cycle after that byte.
// i_in.ready drops once the queue holds three or more beats, keeping room for
// the two beats one byte can push; with o_out stalled, at most three
// result-carrying bytes are taken before i_in backs up.
// Reset (synchronous, active low) clears the phase machine, the queue and
// the search tag (to 0).
module tlv_field_finder_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tlvff_byte_if.sink     i_in,
    tlvff_result_if.source o_out,
    tlvff_cfg_if.sink      i_cfg
);

    logic [7:0]                r_search_tag;
    logic                      in_fire;
    tlvff_pkg::t_push_req      push;
    tlvff_pkg::t_queue_status  q_status;

    // tag register: a write is seen from the next tag byte on
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_tag <= '0;
        end else if (i_cfg.valid) begin
            r_search_tag <= i_cfg.search_tag;
        end
    end

    // room for the worst case of two results per byte
    assign i_in.ready = q_status.has_room;
    assign in_fire    = i_in.valid & i_in.ready;

    tlvff_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (in_fire),
        .i_data_byte  (i_in.data_byte),
        .i_block_end  (i_in.block_end),
        .i_search_tag (r_search_tag),
        .o_push       (push)
    );

    tlvff_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_status (q_status),
        .o_out    (o_out)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.count <= tlvff_pkg::QCOUNT_W'(tlvff_pkg::QDEPTH))
        else $error("result queue overflow");

    a_end_gives_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in.block_end |=> o_out.valid)
        else $error("block end produced no result");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.item_kind == tlvff_pkg::KIND_STATUS) == o_out.is_last)
        else $error("is_last does not match item kind");

    a_value_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.item_kind == tlvff_pkg::KIND_VALUE
        |-> o_out.search_status == tlvff_pkg::ST_SUCCESS && o_out.value_length != 16'd0)
        else $error("value beat with bad status or zero length");
`endif

endmodule

[rtl/tlvff_parser.sv]
// TLV header/value phase machine; turns one accepted byte into up to two
// queue pushes (value byte, end-of-block status). Depends on tlvff_pkg.
module tlvff_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_block_end,
    input  logic [7:0]           i_search_tag,
    output tlvff_pkg::t_push_req o_push
);

    tlvff_pkg::t_phase r_phase, n_phase, step_phase;
    logic [15:0]       r_rem, n_rem;
    logic              r_match, n_match;
    logic              r_done, n_done;
    logic [15:0]       r_found_len, n_found_len;
    logic              unit_end;

    // next phase
    always_comb begin
        unit_end   = 1'b0;
        step_phase = r_phase;
        case (r_phase)
            tlvff_pkg::PH_TAG:    step_phase = tlvff_pkg::PH_LEN_HI;
            tlvff_pkg::PH_LEN_HI: step_phase = tlvff_pkg::PH_LEN_LO;
            tlvff_pkg::PH_LEN_LO: begin
                if ({r_rem[15:8], i_data_byte} == 16'd0) begin
                    unit_end = 1'b1;
                end else begin
                    step_phase = tlvff_pkg::PH_VALUE;
                end
            end
            tlvff_pkg::PH_VALUE: begin
                if (r_rem == 16'd1) begin
                    unit_end = 1'b1;
                end
            end
            default: step_phase = r_phase;
        endcase
        if (unit_end) begin
            step_phase = r_match ? tlvff_pkg::PH_DONE : tlvff_pkg::PH_TAG;
        end
        n_phase = i_block_end ? tlvff_pkg::PH_TAG : step_phase;
    end

    // datapath and pushes
    always_comb begin
        logic [15:0] step_rem;
        logic        step_match;
        logic        step_done;
        logic [15:0] step_found;
        step_rem   = r_rem;
        step_match = r_match;
        step_found = r_found_len;
        o_push     = '0;
        case (r_phase)
            tlvff_pkg::PH_TAG:    step_match = (i_data_byte == i_search_tag);
            tlvff_pkg::PH_LEN_HI: step_rem = {i_data_byte, 8'h00};
            tlvff_pkg::PH_LEN_LO: begin
                step_rem = {r_rem[15:8], i_data_byte};
                if (r_match) begin
                    step_found = {r_rem[15:8], i_data_byte};
                end
            end
            tlvff_pkg::PH_VALUE: begin
                step_rem = r_rem - 16'd1;
                if (r_match) begin
                    o_push.val_en                 = i_fire;
                    o_push.val_item.item_kind     = tlvff_pkg::KIND_VALUE;
                    o_push.val_item.value_byte    = i_data_byte;
                    o_push.val_item.value_length  = r_found_len;
                    o_push.val_item.search_status = tlvff_pkg::ST_SUCCESS;
                    o_push.val_item.is_last       = 1'b0;
                end
            end
            default: step_rem = r_rem;
        endcase
        step_done = r_done | (unit_end & r_match);

        o_push.stat_en             = i_fire & i_block_end;
        o_push.stat_item.item_kind = tlvff_pkg::KIND_STATUS;
        o_push.stat_item.is_last   = 1'b1;
        if (step_done) begin
            o_push.stat_item.search_status = tlvff_pkg::ST_SUCCESS;
            o_push.stat_item.value_length  = step_found;
        end else if (step_phase == tlvff_pkg::PH_TAG) begin
            o_push.stat_item.search_status = tlvff_pkg::ST_NOT_FOUND;
        end else begin
            o_push.stat_item.search_status = tlvff_pkg::ST_MALFORMED;
        end

        // block end clears all per-block state
        n_rem       = i_block_end ? 16'd0 : step_rem;
        n_match     = i_block_end ? 1'b0 : step_match;
        n_done      = i_block_end ? 1'b0 : step_done;
        n_found_len = i_block_end ? 16'd0 : step_found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= tlvff_pkg::PH_TAG;
            r_rem       <= '0;
            r_match     <= 1'b0;
            r_done      <= 1'b0;
            r_found_len <= '0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_rem       <= n_rem;
            r_match     <= n_match;
            r_done      <= n_done;
            r_found_len <= n_found_len;
        end
    end

endmodule

[rtl/tlvff_out_queue.sv]
// Small result queue: takes up to two beats per cycle, releases one per cycle while o_out.ready is high.
// Depends on tlvff_pkg and tlvff_result_if.
module tlvff_out_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  tlvff_pkg::t_push_req     i_push,
    output tlvff_pkg::t_queue_status o_status,
    tlvff_result_if.source           o_out
);

    localparam int PW = tlvff_pkg::QPTR_W;
    localparam int CW = tlvff_pkg::QCOUNT_W;

    tlvff_pkg::t_result r_mem [tlvff_pkg::QDEPTH];
    logic [PW-1:0]      r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]      r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]      r_count, n_count;
    logic               pop;
    logic [CW-1:0]      push_cnt;
    logic [PW-1:0]      stat_ptr;

    assign pop      = o_out.valid & o_out.ready;
    assign push_cnt = CW'(i_push.val_en) + CW'(i_push.stat_en);
    assign stat_ptr = r_wr_ptr + PW'(i_push.val_en);
    assign n_wr_ptr = r_wr_ptr + PW'(push_cnt);
    assign n_rd_ptr = r_rd_ptr + PW'(pop);
    assign n_count  = r_count + push_cnt - CW'(pop);

    assign o_status.count    = r_count;
    assign o_status.has_room = (r_count <= CW'(tlvff_pkg::QDEPTH - 2));

    assign o_out.valid         = (r_count != '0);
    assign o_out.item_kind     = r_mem[r_rd_ptr].item_kind;
    assign o_out.value_byte    = r_mem[r_rd_ptr].value_byte;
    assign o_out.value_length  = r_mem[r_rd_ptr].value_length;
    assign o_out.search_status = r_mem[r_rd_ptr].search_status;
    assign o_out.is_last       = r_mem[r_rd_ptr].is_last;

    always_ff @(posedge i_clk) begin
        if (i_push.val_en) begin
            r_mem[r_wr_ptr] <= i_push.val_item;
        end
        if (i_push.stat_en) begin
            r_mem[stat_ptr] <= i_push.stat_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[tb/tb_tlv_field_finder_unit.sv]
// Testbench for tlv_field_finder_unit: random and directed TLV blocks, a
// built-in tracker of the expected result beats, and field-by-field checking.
// Depends on tlvff_pkg, tlvff_ifs and the RTL of the unit.
`timescale 1ns / 1ps

module tb_tlv_field_finder_unit;

    localparam int SETTLE_CYCLES = 4;       // quiet edges before a tag write
    localparam int CYCLE_LIMIT   = 200000;  // hard stop for a hung run
    localparam int IDLE_PCT      = 20;      // chance of a gap / stall per cycle

    // What the driver can be asked to do next.
    typedef enum logic [1:0] {
        STIM_BYTE,       // one byte beat on i_in
        STIM_TAG_WRITE,  // write search_tag once the unit is quiet
        STIM_HOLD        // stop sending until every result has drained
    } t_stim_kind;

    typedef struct {
        t_stim_kind kind;
        logic [7:0] data;
        logic       last;
    } t_stim;

    logic i_clk;
    logic i_rst_n;

    tlvff_byte_if   in_if ();
    tlvff_result_if out_if ();
    tlvff_cfg_if    cfg_if ();

    tlv_field_finder_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Pending stimulus, filled up front by the initial block below.
    t_stim                stim_q[$];
    // Result beats the finder owes us, oldest first.
    tlvff_pkg::t_result   owed_q[$];
    // Scratch for assembling one block before it is queued.
    logic [7:0]           blk[$];

    int bytes_queued = 0;
    int bytes_done   = 0;
    int settle_cnt   = 0;
    int err_cnt      = 0;
    int cycle_cnt    = 0;

    // Long window with no gaps on either side, part way through the run.
    logic calm;
    assign calm = (bytes_done >= 500) && (bytes_done < 800);

    // ------------------------------------------------------------------
    // Tracker of the search state, advanced once per accepted byte.
    // ------------------------------------------------------------------
    logic [7:0]        trk_tag      = 8'h00;  // search_tag as the unit holds it
    tlvff_pkg::t_phase trk_phase    = tlvff_pkg::PH_TAG;
    logic [15:0]       trk_remain   = 16'h0000;
    logic              trk_matching = 1'b0;
    logic              trk_complete = 1'b0;
    logic [15:0]       trk_found    = 16'h0000;

    function automatic void search_step(logic [7:0] b, logic last);
        tlvff_pkg::t_result r;
        case (trk_phase)
            tlvff_pkg::PH_TAG: begin
                // tag is compared against the register at every tag byte
                trk_matching = (b == trk_tag);
                trk_phase    = tlvff_pkg::PH_LEN_HI;
            end
            tlvff_pkg::PH_LEN_HI: begin
                trk_remain = {b, 8'h00};
                trk_phase  = tlvff_pkg::PH_LEN_LO;
            end
            tlvff_pkg::PH_LEN_LO: begin
                trk_remain[7:0] = b;
                if (trk_matching)
                    trk_found = trk_remain;
                // a zero-length unit is finished at its second length byte
                if (trk_remain == 16'h0000) begin
                    if (trk_matching) begin
                        trk_complete = 1'b1;
                        trk_phase    = tlvff_pkg::PH_DONE;
                    end else begin
                        trk_phase = tlvff_pkg::PH_TAG;
                    end
                end else begin
                    trk_phase = tlvff_pkg::PH_VALUE;
                end
            end
            tlvff_pkg::PH_VALUE: begin
                if (trk_matching) begin
                    r.item_kind     = tlvff_pkg::KIND_VALUE;
                    r.value_byte    = b;
                    r.value_length  = trk_found;
                    r.search_status = tlvff_pkg::ST_SUCCESS;
                    r.is_last       = 1'b0;
                    owed_q.push_back(r);
                end
                trk_remain = trk_remain - 16'd1;
                if (trk_remain == 16'h0000) begin
                    if (trk_matching) begin
                        trk_complete = 1'b1;
                        trk_phase    = tlvff_pkg::PH_DONE;
                    end else begin
                        trk_phase = tlvff_pkg::PH_TAG;
                    end
                end
            end
            default: ;  // done: bytes after a complete match are dropped
        endcase

        if (last) begin
            r.item_kind    = tlvff_pkg::KIND_STATUS;
            r.value_byte   = 8'h00;
            r.value_length = 16'h0000;
            r.is_last      = 1'b1;
            if (trk_complete) begin
                r.search_status = tlvff_pkg::ST_SUCCESS;
                r.value_length  = trk_found;
            end else if (trk_phase == tlvff_pkg::PH_TAG) begin
                r.search_status = tlvff_pkg::ST_NOT_FOUND;
            end else begin
                // ended inside a header or a value
                r.search_status = tlvff_pkg::ST_MALFORMED;
            end
            owed_q.push_back(r);
            trk_phase    = tlvff_pkg::PH_TAG;
            trk_remain   = 16'h0000;
            trk_matching = 1'b0;
            trk_complete = 1'b0;
            trk_found    = 16'h0000;
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        err_cnt++;
        if (err_cnt <= 40)
            $display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic put_byte(logic [7:0] b, logic last);
        t_stim s;
        s.kind = STIM_BYTE;
        s.data = b;
        s.last = last;
        stim_q.push_back(s);
        bytes_queued++;
    endtask

    task automatic put_stim(t_stim_kind k, logic [7:0] d);
        t_stim s;
        s.kind = k;
        s.data = d;
        s.last = 1'b0;
        stim_q.push_back(s);
    endtask

    // Appends one unit: tag, big-endian length, random value bytes.
    task automatic add_unit(logic [7:0] tag, int len);
        logic [15:0] l16;
        l16 = len[15:0];
        blk.push_back(tag);
        blk.push_back(l16[15:8]);
        blk.push_back(l16[7:0]);
        for (int i = 0; i < len; i++)
            blk.push_back(8'($urandom_range(255)));
    endtask

    // Queues the scratch block minus its last cut bytes. close marks the
    // final beat as block_end; without it the block continues later.
    task automatic ship_block(int cut, bit close);
        int n;
        n = blk.size() - cut;
        for (int i = 0; i < n; i++)
            put_byte(blk[i], close && (i == n - 1));
        blk.delete();
    endtask

    // Mostly short values, a few medium, a rare one past 255 bytes.
    function automatic int pick_len();
        int r;
        r = $urandom_range(999);
        if (r < 5)
            return $urandom_range(256, 280);
        if (r < 95)
            return $urandom_range(6, 24);
        return $urandom_range(0, 5);
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Cycle limit: a run that hangs fails here.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: byte beats and tag writes, one step per rising edge.
    // Accepted beats feed the tracker at the edge they are taken.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_stim nxt;
        logic  in_v;
        logic  cfg_v;
        if (!i_rst_n) begin
            in_if.valid      <= 1'b0;
            in_if.data_byte  <= 8'h00;
            in_if.block_end  <= 1'b0;
            cfg_if.valid     <= 1'b0;
            cfg_if.search_tag <= 8'h00;
            settle_cnt = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                search_step(in_if.data_byte, in_if.block_end);
                bytes_done++;
            end
            if (cfg_if.valid && cfg_if.ready)
                trk_tag = cfg_if.search_tag;

            // Quiet means nothing owed and no beat offered for a few edges,
            // so the unit has no byte still in flight.
            if (owed_q.size() != 0 || in_if.valid || cfg_if.valid)
                settle_cnt = 0;
            else if (settle_cnt < SETTLE_CYCLES)
                settle_cnt++;

            // A beat not yet taken stays on the bus unchanged.
            in_v  = in_if.valid && !in_if.ready;
            cfg_v = cfg_if.valid && !cfg_if.ready;

            if (!in_v && !cfg_v && stim_q.size() != 0) begin
                nxt = stim_q[0];
                case (nxt.kind)
                    STIM_BYTE: begin
                        if (calm || $urandom_range(99) >= IDLE_PCT) begin
                            in_if.data_byte <= nxt.data;
                            in_if.block_end <= nxt.last;
                            in_v = 1'b1;
                            void'(stim_q.pop_front());
                        end
                    end
                    STIM_TAG_WRITE: begin
                        if (settle_cnt >= SETTLE_CYCLES) begin
                            cfg_if.search_tag <= nxt.data;
                            cfg_v = 1'b1;
                            void'(stim_q.pop_front());
                        end
                    end
                    default: begin
                        // hold: resume only once all results are out
                        if (settle_cnt >= SETTLE_CYCLES)
                            void'(stim_q.pop_front());
                    end
                endcase
            end
            in_if.valid  <= in_v;
            cfg_if.valid <= cfg_v;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: takes result beats with random back-pressure and checks
    // each against the oldest owed beat.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        tlvff_pkg::t_result want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (owed_q.size() == 0) begin
                    report_mismatch("unexpected result beat, kind",
                                    int'(out_if.item_kind), 0);
                end else begin
                    want = owed_q.pop_front();
                    if (out_if.item_kind !== want.item_kind)
                        report_mismatch("item_kind", int'(out_if.item_kind),
                                        int'(want.item_kind));
                    if (out_if.value_byte !== want.value_byte)
                        report_mismatch("value_byte", int'(out_if.value_byte),
                                        int'(want.value_byte));
                    if (out_if.value_length !== want.value_length)
                        report_mismatch("value_length", int'(out_if.value_length),
                                        int'(want.value_length));
                    if (out_if.search_status !== want.search_status)
                        report_mismatch("search_status", int'(out_if.search_status),
                                        int'(want.search_status));
                    if (out_if.is_last !== want.is_last)
                        report_mismatch("is_last", int'(out_if.is_last),
                                        int'(want.is_last));
                end
            end
            out_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus plan, then end of run.
    // ------------------------------------------------------------------
    initial begin
        logic [7:0] gen_tag;
        int         blk_no;
        int         n_units;
        int         hit_at;
        int         style;
        int         cut;
        int         guard;
        logic [7:0] tag;

        // Directed part, search tag 0 out of reset.
        // One-byte block: the tag matches but the header is cut -> malformed.
        put_byte(8'h00, 1'b1);

        // Highest tag, two value bytes ending exactly on block_end.
        put_stim(STIM_TAG_WRITE, 8'hFF);
        blk = '{8'hFF, 8'h00, 8'h02, 8'hAA, 8'h55};
        ship_block(0, 1'b1);

        // Zero-length non-matching unit, then a zero-length match.
        blk = '{8'h01, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00};
        ship_block(0, 1'b1);

        // Tag changes mid-block: the next tag byte sees the new value.
        blk = '{8'h07, 8'h00, 8'h01, 8'h33};
        ship_block(0, 1'b0);
        put_stim(STIM_TAG_WRITE, 8'h07);
        blk = '{8'h07, 8'h00, 8'h00};
        ship_block(0, 1'b1);

        // Clean end with no match -> not found.
        blk = '{8'h3C, 8'h00, 8'h01, 8'h00};
        ship_block(0, 1'b1);

        // Largest length, value cut short after one byte -> malformed.
        blk = '{8'h07, 8'hFF, 8'hFF, 8'h12};
        ship_block(0, 1'b1);

        // Random part: mostly well-formed blocks with random content.
        gen_tag = 8'h07;
        blk_no  = 0;
        while (bytes_queued < 1330) begin
            if (blk_no % 30 == 29) begin
                case ((blk_no / 30) % 3)
                    0:       gen_tag = 8'h00;
                    1:       gen_tag = 8'hFF;
                    default: gen_tag = 8'($urandom_range(255));
                endcase
                put_stim(STIM_TAG_WRITE, gen_tag);
            end
            // sender waits for a full drain at least once
            if (blk_no == 45 || $urandom_range(99) < 3)
                put_stim(STIM_HOLD, 8'h00);

            n_units = $urandom_range(1, 4);
            hit_at  = ($urandom_range(99) < 60) ? $urandom_range(0, n_units - 1) : -1;
            for (int u = 0; u < n_units; u++) begin
                tag = (u == hit_at) ? gen_tag : 8'($urandom_range(255));
                add_unit(tag, pick_len());
                // occasional tag write between units of one block
                if (u + 1 < n_units && $urandom_range(99) < 2) begin
                    ship_block(0, 1'b0);
                    gen_tag = 8'($urandom_range(255));
                    put_stim(STIM_TAG_WRITE, gen_tag);
                end
            end

            cut   = 0;
            style = $urandom_range(99);
            if (style < 12 && blk.size() >= 2) begin
                // truncated inside a header or a value
                cut = $urandom_range(1, (blk.size() - 1 < 3) ? blk.size() - 1 : 3);
            end else if (style < 22) begin
                // trailing bytes after the last unit
                repeat ($urandom_range(1, 4))
                    blk.push_back(8'($urandom_range(255)));
            end else if (style < 28) begin
                // pure noise
                blk.delete();
                repeat ($urandom_range(1, 8))
                    blk.push_back(8'($urandom_range(255)));
            end
            if (blk.size() == 0)
                blk.push_back(8'($urandom_range(255)));
            ship_block(cut, 1'b1);
            blk_no++;
        end

        // All stimulus taken, then wait for the owed results to drain.
        @(posedge i_clk);
        while (stim_q.size() != 0 || in_if.valid || cfg_if.valid)
            @(posedge i_clk);
        guard = 0;
        while (owed_q.size() != 0 && guard < 2000) begin
            @(posedge i_clk);
            guard++;
        end
        if (owed_q.size() != 0)
            report_mismatch("results never delivered, count", 0, owed_q.size());
        repeat (16) @(posedge i_clk);

        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
